### rtl/usm_pkg.sv
// Shared types, constants and helpers of the unsharp mask block.
package usm_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_ROWS   = 4096;
    localparam int RING_ROWS  = 8;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int RING_W     = $clog2(RING_ROWS);
    localparam int ADDR_W     = RING_W + COL_W;
    localparam int ACC_W      = 27;
    localparam int WSUM_W     = 19;

    // configuration register indexes
    localparam logic [2:0] CFG_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_CHAN   = 3'd2;
    localparam logic [2:0] CFG_CENTER = 3'd3;
    localparam logic [2:0] CFG_NEAR   = 3'd4;
    localparam logic [2:0] CFG_FAR    = 3'd5;
    localparam logic [2:0] CFG_AMOUNT = 3'd6;

    // tap index of the centre of the 5-tap window
    localparam logic [2:0] TAP_MID = 3'd2;
    localparam logic [2:0] TAP_END = 3'd4;
    localparam logic [2:0] DIV_END = 3'd7;

    typedef struct packed {
        logic       store;
        logic       vclr;
        logic       hclr;
        logic       hrd;
        logic [2:0] kx;
        logic [2:0] ky;
        logic       dload_h;
        logic       dload_v;
        logic       dstep;
        logic       vacc;
        logic       emit;
    } t_cmd;

    typedef struct packed {
        logic ready;
        logic out_free;
    } t_stat;

    // weight of the tap at window index 0..4
    function automatic logic [15:0] tap_weight(input logic [2:0] k, input logic [15:0] wc,
                                               input logic [15:0] wn, input logic [15:0] wf);
        logic [15:0] w;
        case (k)
            3'd2:         w = wc;
            3'd1, 3'd3:   w = wn;
            default:      w = wf;
        endcase
        return w;
    endfunction

endpackage

### rtl/usm_ctrl.sv
// Sequencer of the blur passes, division steps and result hand-off.
module usm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  usm_pkg::t_stat i_stat,
    output usm_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_HCLR, S_HREAD, S_HWAIT, S_HLOAD, S_HDIV,
        S_VACC, S_VLOAD, S_VDIV, S_EMIT
    } t_state;

    t_state     r_state;
    logic [2:0] r_kx, r_ky, r_step;

    assign o_in_ready = (r_state == S_IDLE);

    // decode commands from state
    always_comb begin
        o_cmd         = '0;
        o_cmd.kx      = r_kx;
        o_cmd.ky      = r_ky;
        o_cmd.store   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.vclr    = (r_state == S_CHECK);
        o_cmd.hclr    = (r_state == S_HCLR);
        o_cmd.hrd     = (r_state == S_HREAD);
        o_cmd.dload_h = (r_state == S_HLOAD);
        o_cmd.dload_v = (r_state == S_VLOAD);
        o_cmd.dstep   = (r_state == S_HDIV) || (r_state == S_VDIV);
        o_cmd.vacc    = (r_state == S_VACC);
        o_cmd.emit    = (r_state == S_EMIT) && i_stat.out_free;
    end

    // advance the sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kx    <= '0;
            r_ky    <= '0;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE:  if (i_in_valid) r_state <= S_CHECK;
                S_CHECK: begin
                    r_ky    <= '0;
                    r_state <= i_stat.ready ? S_HCLR : S_IDLE;
                end
                S_HCLR: begin
                    r_kx    <= '0;
                    r_state <= S_HREAD;
                end
                S_HREAD: begin
                    r_kx <= r_kx + 3'd1;
                    if (r_kx == usm_pkg::TAP_END) r_state <= S_HWAIT;
                end
                S_HWAIT: r_state <= S_HLOAD;
                S_HLOAD: begin
                    r_step  <= '0;
                    r_state <= S_HDIV;
                end
                S_HDIV: begin
                    r_step <= r_step + 3'd1;
                    if (r_step == usm_pkg::DIV_END) r_state <= S_VACC;
                end
                S_VACC: begin
                    if (r_ky == usm_pkg::TAP_END) begin
                        r_state <= S_VLOAD;
                    end else begin
                        r_ky    <= r_ky + 3'd1;
                        r_state <= S_HCLR;
                    end
                end
                S_VLOAD: begin
                    r_step  <= '0;
                    r_state <= S_VDIV;
                end
                S_VDIV: begin
                    r_step <= r_step + 3'd1;
                    if (r_step == usm_pkg::DIV_END) r_state <= S_EMIT;
                end
                S_EMIT:  if (i_stat.out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### rtl/usm_dp.sv
// Datapath: registers, positions, row store, blur accumulators, dividers, sharpen.
module usm_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_addr,
    input  logic [15:0]   i_cfg_wdata,
    input  logic          i_action,
    input  logic [23:0]   i_pixel,
    input  usm_pkg::t_cmd i_cmd,
    output usm_pkg::t_stat o_stat,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output logic [23:0]   o_out_data,
    output logic          o_out_last
);

    localparam int CW = usm_pkg::COL_W;
    localparam int RW = usm_pkg::ROW_W;
    localparam int AW = usm_pkg::ACC_W;
    localparam int QW = usm_pkg::WSUM_W;

    // configuration
    logic [11:0] r_width_raw;
    logic [12:0] r_height_raw;
    logic [1:0]  r_chan_raw;
    logic [15:0] r_wc, r_wn, r_wf;
    logic [11:0] r_amount;

    // positions
    logic [CW-1:0] r_in_col;
    logic [RW-1:0] r_in_row;
    logic          r_full;
    logic [CW-1:0] r_out_col;
    logic [RW:0]   r_out_row;

    // effective geometry
    logic [CW:0] eff_w;
    logic [RW:0] eff_h;
    logic [1:0]  eff_ch;
    always_comb begin
        if (r_width_raw == '0)                    eff_w = 12'd1;
        else if (r_width_raw > 12'(usm_pkg::MAX_WIDTH)) eff_w = 12'(usm_pkg::MAX_WIDTH);
        else                                      eff_w = r_width_raw;
        if (r_height_raw == '0)                   eff_h = 13'd1;
        else if (r_height_raw > 13'(usm_pkg::MAX_ROWS)) eff_h = 13'(usm_pkg::MAX_ROWS);
        else                                      eff_h = r_height_raw;
        eff_ch = (r_chan_raw == 2'd0) ? 2'd1 : r_chan_raw;
    end

    // readiness of the next result
    logic [RW:0] nr, row_p2;
    logic [CW:0] nc, col_p2;
    logic        got_past;
    always_comb begin
        row_p2   = r_out_row + 13'd2;
        col_p2   = {1'b0, r_out_col} + 12'd2;
        nr       = (row_p2 > eff_h - 13'd1) ? eff_h - 13'd1 : row_p2;
        nc       = (col_p2 > eff_w - 12'd1) ? eff_w - 12'd1 : col_p2;
        got_past = ({1'b0, r_in_row} > nr) ||
                   (({1'b0, r_in_row} == nr) && ({1'b0, r_in_col} > nc));
        o_stat.ready    = (r_out_row < eff_h) && (r_full || got_past);
        o_stat.out_free = !o_out_valid || i_out_ready;
    end

    // pixel write position
    logic [CW-1:0] wr_col;
    logic [RW-1:0] wr_row;
    logic          store_px;
    assign store_px = i_cmd.store && !i_action;
    assign wr_col   = r_full ? '0 : r_in_col;
    assign wr_row   = r_full ? '0 : r_in_row;

    logic geo_write;
    assign geo_write = i_cfg_we && (i_cfg_addr == usm_pkg::CFG_WIDTH ||
                                    i_cfg_addr == usm_pkg::CFG_HEIGHT ||
                                    i_cfg_addr == usm_pkg::CFG_CHAN);

    // hold registers and positions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_raw  <= 12'd640;
            r_height_raw <= 13'd480;
            r_chan_raw   <= 2'd3;
            r_wc         <= 16'd19142;
            r_wn         <= 16'd15327;
            r_wf         <= 16'd7870;
            r_amount     <= 12'd384;
            r_in_col     <= '0;
            r_in_row     <= '0;
            r_full       <= 1'b0;
            r_out_col    <= '0;
            r_out_row    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    usm_pkg::CFG_WIDTH:  r_width_raw  <= i_cfg_wdata[11:0];
                    usm_pkg::CFG_HEIGHT: r_height_raw <= i_cfg_wdata[12:0];
                    usm_pkg::CFG_CHAN:   r_chan_raw   <= i_cfg_wdata[1:0];
                    usm_pkg::CFG_CENTER: r_wc         <= i_cfg_wdata;
                    usm_pkg::CFG_NEAR:   r_wn         <= i_cfg_wdata;
                    usm_pkg::CFG_FAR:    r_wf         <= i_cfg_wdata;
                    usm_pkg::CFG_AMOUNT: r_amount     <= i_cfg_wdata[11:0];
                    default: ;
                endcase
            end
            if (geo_write) begin
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_full    <= 1'b0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else if (store_px) begin
                if ({1'b0, wr_col} + 12'd1 >= eff_w) begin
                    r_in_col <= '0;
                    if ({1'b0, wr_row} + 13'd1 >= eff_h) begin
                        r_in_row <= '0;
                        r_full   <= 1'b1;
                    end else begin
                        r_in_row <= wr_row + 12'd1;
                        r_full   <= 1'b0;
                    end
                end else begin
                    r_in_col <= wr_col + 11'd1;
                    r_in_row <= wr_row;
                    r_full   <= 1'b0;
                end
                if (r_full) begin
                    r_out_col <= '0;
                    r_out_row <= '0;
                end
            end else if (i_cmd.emit) begin
                if ({1'b0, r_out_col} + 12'd1 >= eff_w) begin
                    r_out_col <= '0;
                    r_out_row <= r_out_row + 13'd1;
                end else begin
                    r_out_col <= r_out_col + 11'd1;
                end
            end
        end
    end

    // neighbour position and bounds
    logic signed [RW+1:0] nb_row;
    logic signed [CW+1:0] nb_col;
    logic                 row_ok, col_ok;
    always_comb begin
        nb_row = $signed({1'b0, r_out_row}) + $signed({{(RW-1){1'b0}}, i_cmd.ky}) - 14'sd2;
        nb_col = $signed({2'b0, r_out_col}) + $signed({{(CW-1){1'b0}}, i_cmd.kx}) - 13'sd2;
        row_ok = (nb_row >= 0) && (nb_row < $signed({1'b0, eff_h}));
        col_ok = (nb_col >= 0) && (nb_col < $signed({1'b0, eff_w}));
    end

    // row store: write on pixel, registered read
    logic [23:0]                  mem [0:(1 << usm_pkg::ADDR_W)-1];
    logic [23:0]                  r_mem_q;
    logic [usm_pkg::ADDR_W-1:0]   rd_addr;
    assign rd_addr = {nb_row[usm_pkg::RING_W-1:0], nb_col[CW-1:0]};
    always_ff @(posedge i_clk) begin
        if (store_px) mem[{wr_row[usm_pkg::RING_W-1:0], wr_col}] <= i_pixel;
        if (i_cmd.hrd) r_mem_q <= mem[rd_addr];
    end

    // tag the read under way
    logic        r_p1_v, r_p1_ctr;
    logic [15:0] r_p1_w;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v   <= 1'b0;
            r_p1_ctr <= 1'b0;
        end else begin
            r_p1_v   <= i_cmd.hrd && row_ok && col_ok;
            r_p1_ctr <= i_cmd.hrd && (i_cmd.kx == usm_pkg::TAP_MID);
        end
        r_p1_w <= usm_pkg::tap_weight(i_cmd.kx, r_wc, r_wn, r_wf);
    end

    // horizontal and vertical accumulators, shared dividers
    logic [AW-1:0] r_hs [3];
    logic [QW-1:0] r_hq, r_vq;
    logic [AW-1:0] r_vs [3];
    logic [23:0]   r_hctr, r_vctr, r_orig;
    logic [AW-1:0] r_rem [3];
    logic [AW-1:0] r_dvs;
    logic [7:0]    r_quo [3];
    logic [7:0]    hres [3];
    logic [7:0]    vres [3];
    logic [15:0]   wv;

    assign wv = usm_pkg::tap_weight(i_cmd.ky, r_wc, r_wn, r_wf);

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            hres[c] = (r_hq == '0) ? r_hctr[8*c +: 8] : r_quo[c];
            vres[c] = (r_vq == '0) ? r_vctr[8*c +: 8] : r_quo[c];
        end
    end

    always_ff @(posedge i_clk) begin
        // horizontal pass
        if (i_cmd.hclr) begin
            for (int c = 0; c < 3; c++) r_hs[c] <= '0;
            r_hq <= '0;
        end else if (r_p1_v) begin
            for (int c = 0; c < 3; c++)
                r_hs[c] <= r_hs[c] + AW'({8'b0, r_p1_w} * {16'b0, r_mem_q[8*c +: 8]});
            r_hq <= r_hq + QW'(r_p1_w);
        end
        if (r_p1_ctr) r_hctr <= r_mem_q;
        // vertical pass
        if (i_cmd.vclr) begin
            for (int c = 0; c < 3; c++) r_vs[c] <= '0;
            r_vq <= '0;
        end else if (i_cmd.vacc) begin
            if (row_ok) begin
                for (int c = 0; c < 3; c++)
                    r_vs[c] <= r_vs[c] + AW'({8'b0, wv} * {16'b0, hres[c]});
                r_vq <= r_vq + QW'(wv);
            end
            if (i_cmd.ky == usm_pkg::TAP_MID) begin
                r_vctr <= {hres[2], hres[1], hres[0]};
                r_orig <= r_hctr;
            end
        end
        // restoring division, one quotient bit a step
        if (i_cmd.dload_h || i_cmd.dload_v) begin
            for (int c = 0; c < 3; c++) begin
                r_rem[c] <= i_cmd.dload_h ? r_hs[c] : r_vs[c];
                r_quo[c] <= '0;
            end
            r_dvs <= AW'({i_cmd.dload_h ? r_hq : r_vq, 7'b0});
        end else if (i_cmd.dstep) begin
            for (int c = 0; c < 3; c++) begin
                if (r_rem[c] >= r_dvs) begin
                    r_rem[c] <= r_rem[c] - r_dvs;
                    r_quo[c] <= {r_quo[c][6:0], 1'b1};
                end else begin
                    r_quo[c] <= {r_quo[c][6:0], 1'b0};
                end
            end
            r_dvs <= r_dvs >> 1;
        end
    end

    // sharpen one channel
    function automatic logic [7:0] sharpen(input logic [7:0] o, input logic [7:0] b,
                                           input logic [11:0] a);
        logic signed [8:0]  d;
        logic signed [22:0] ad;
        logic signed [22:0] t;
        logic [7:0]         r;
        d  = $signed({1'b0, o}) - $signed({1'b0, b});
        ad = $signed({11'b0, a}) * $signed({{14{d[8]}}, d});
        t  = $signed({7'b0, o, 8'b0}) + ad;
        if (t < 0)                 r = 8'd0;
        else if (t > 23'sd65280)   r = 8'd255;
        else                       r = 8'(23'(t + 23'sd128) >> 8);
        return r;
    endfunction

    // output register
    logic [23:0] res;
    always_comb begin
        for (int c = 0; c < 3; c++)
            res[8*c +: 8] = (2'(c) < eff_ch) ? sharpen(r_orig[8*c +: 8], vres[c], r_amount)
                                             : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
        if (i_cmd.emit) begin
            o_out_data <= res;
            o_out_last <= (r_out_row == eff_h - 13'd1) &&
                          ({1'b0, r_out_col} == eff_w - 12'd1);
        end
    end

endmodule

### rtl/separable_gaussian_unsharp_mask.sv
// Top level of the streaming unsharp mask with separable 5-tap Gaussian blur.
//
// Input words arrive on the s_axis group in raster order: tuser is the
// action (0 pixel, 1 flush one pending result), tdata the channel bytes.
// Results leave on the m_axis group; tlast marks the last pixel of a frame.
// Registers are written through i_cfg_we / i_cfg_addr / i_cfg_wdata; the user
// must write them only while the block is idle, which the block does not
// enforce. A geometry write restarts the frame. One word is worked on at a
// time. A word yielding no result goes back to idle after the check; a word
// yielding a result runs five rows (clear, five row-store reads, read wait,
// load, 8-step divide, vertical accumulate), then a load and the vertical
// 8-step divide, set by the single-port row store and shared divider lanes.
// The result sits in an output register; the next word is accepted while it
// waits. If the receiver stalls with the register full, the block holds the
// following result until the register is taken.
// Reset (synchronous, active low) restores the default registers and an
// empty frame; the row store content is left as is.
module separable_gaussian_unsharp_mask (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // chan0, chan1, chan2
    input  logic        s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // out0, out1, out2
    output logic        m_axis_tlast    // frame_end
);

    usm_pkg::t_cmd  cmd;
    usm_pkg::t_stat stat;

    usm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    usm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_action    (s_axis_tuser),
        .i_pixel     (s_axis_tdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule
